@@ src/sha1md_pkg.sv @@
`timescale 1ns / 1ps

package sha1md_pkg;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] BLOCK_END    = 6'd63;

  localparam logic [6:0] ROUND_LOADED = 7'd15;
  localparam logic [6:0] ROUND_FIRST  = 7'd16;
  localparam logic [6:0] ROUND_B1     = 7'd20;
  localparam logic [6:0] ROUND_B2     = 7'd40;
  localparam logic [6:0] ROUND_B3     = 7'd60;
  localparam logic [6:0] ROUND_LAST   = 7'd79;

  typedef struct packed {
    logic        last_word;
    logic [31:0] word;
  } q_entry_t;

  typedef enum logic [3:0] {
    F_IDLE     = 4'b0001,
    F_PAD_ONE  = 4'b0010,
    F_PAD_ZERO = 4'b0100,
    F_PAD_LEN  = 4'b1000
  } front_state_t;

  typedef enum logic [2:0] {
    B_LOAD   = 3'b001,
    B_ROUNDS = 3'b010,
    B_FINISH = 3'b100
  } back_state_t;

endpackage

@@ src/sha1_message_digest.sv @@
`timescale 1ns / 1ps

// Streaming SHA-1. One request carries at most one message byte (tuser set)
// and may end the message (tlast). Bytes are taken one per cycle while the
// word queue has room and no padding is under way. The round engine loads a
// block's sixteen words from the queue, running a round with each, then runs
// 64 more rounds and folds the result into the chain, but with the default
// four-word queue the front runs ahead of the rounds by only 16 bytes, so
// input stalls while the rounds run. Ending a message adds 9 to 72 padding
// byte slots at one per cycle in the front while the queue has room, and the
// digest (word 0 in the lowest bits) appears once the last padded block has
// run its rounds and been folded into the chain, later while an earlier
// digest is still waiting. The hasher restarts by itself after each digest.
module sha1_message_digest
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // byte_present
  input  logic         s_axis_tlast,   // end_of_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata    // digest_word0 .. digest_word4
);

  logic     push;
  q_entry_t push_data;
  logic     q_ready;
  logic     q_valid;
  q_entry_t q_data;
  logic     q_pop;

  sha1md_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_push        (push),
    .q_data        (push_data),
    .q_ready       (q_ready)
  );

  sha1md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .ready (q_ready),
    .valid (q_valid),
    .rdata (q_data),
    .pop   (q_pop)
  );

  sha1md_core u_core (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ src/sha1md_front.sv @@
`timescale 1ns / 1ps

module sha1md_front
  import sha1md_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tuser,
  input  logic       s_axis_tlast,
  output logic       q_push,
  output q_entry_t   q_data,
  input  logic       q_ready
);

  front_state_t st;
  logic [5:0]   pos;
  logic [60:0]  byte_cnt;
  logic [60:0]  byte_cnt_next;
  logic [63:0]  len_sr;
  logic [31:0]  wbuf;
  logic [31:0]  wbuf_next;
  logic         accept;
  logic         put;
  logic [7:0]   put_byte;

  assign s_axis_tready = (st == F_IDLE) && q_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign byte_cnt_next = s_axis_tuser ? byte_cnt + 61'd1 : byte_cnt;

  always_comb begin
    put      = 1'b0;
    put_byte = '0;
    case (st)
      F_IDLE: begin
        put      = accept && s_axis_tuser;
        put_byte = s_axis_tdata;
      end
      F_PAD_ONE: begin
        put      = q_ready;
        put_byte = PAD_BYTE;
      end
      F_PAD_ZERO: begin
        put      = q_ready && (pos != LEN_POS);
        put_byte = '0;
      end
      F_PAD_LEN: begin
        put      = q_ready;
        put_byte = len_sr[63:56];
      end
      default: begin
        put      = 1'b0;
        put_byte = '0;
      end
    endcase
  end

  // big-endian packing of four bytes into one word
  assign wbuf_next = ((pos[1:0] == 2'b00) ? 32'd0 : wbuf) |
                     ({24'd0, put_byte} << {~pos[1:0], 3'b000});

  assign q_push = put && (pos[1:0] == 2'b11);
  assign q_data = {(st == F_PAD_LEN) && (pos == BLOCK_END), wbuf_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= F_IDLE;
      pos      <= '0;
      byte_cnt <= '0;
    end else begin
      if (put) begin
        pos <= pos + 6'd1;
      end
      case (st)
        F_IDLE: begin
          if (accept) begin
            byte_cnt <= byte_cnt_next;
            if (s_axis_tlast) begin
              st <= F_PAD_ONE;
            end
          end
        end
        F_PAD_ONE: begin
          if (q_ready) begin
            st <= F_PAD_ZERO;
          end
        end
        F_PAD_ZERO: begin
          if (pos == LEN_POS) begin
            st <= F_PAD_LEN;
          end
        end
        F_PAD_LEN: begin
          if (q_ready && (pos == BLOCK_END)) begin
            st       <= F_IDLE;
            byte_cnt <= '0;
          end
        end
        default: begin
          st <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      wbuf <= wbuf_next;
    end
    if ((st == F_IDLE) && accept && s_axis_tlast) begin
      len_sr <= {byte_cnt_next, 3'b000};
    end else if ((st == F_PAD_LEN) && q_ready) begin
      len_sr <= {len_sr[55:0], 8'd0};
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (st == F_IDLE))
    else $error("input ready outside idle");

  a_len_start: assert property (@(posedge clk) disable iff (rst)
    ((st == F_PAD_LEN) && ($past(st) != F_PAD_LEN)) |-> (pos == LEN_POS))
    else $error("length bytes not aligned to byte 56");
`endif

endmodule

@@ src/sha1md_fifo.sv @@
`timescale 1ns / 1ps

module sha1md_fifo
  import sha1md_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     ready,
  output logic     valid,
  output q_entry_t rdata,
  input  logic     pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW-1:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign ready   = (cnt != CW'(DEPTH));
  assign valid   = (cnt != '0);
  assign rdata   = mem[rptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

@@ src/sha1md_core.sv @@
`timescale 1ns / 1ps

module sha1md_core
  import sha1md_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  q_entry_t     q_data,
  output logic         q_pop,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata
);

  back_state_t  st;
  logic [6:0]   rnd;
  logic [31:0]  chain [5];
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  sr [16];
  logic         last_blk;
  logic         out_valid;
  logic [159:0] out_data;

  logic [31:0]  sched;
  logic [31:0]  wi;
  logic [31:0]  f;
  logic [31:0]  k;
  logic [31:0]  t;
  logic         advance;
  logic         done_ok;
  logic [31:0]  sums [5];
  logic [31:0]  chain_next [5];

  assign sched = sr[13] ^ sr[8] ^ sr[2] ^ sr[0];
  assign wi    = (st == B_LOAD) ? q_data.word : {sched[30:0], sched[31]};

  always_comb begin
    if (rnd < ROUND_B1) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (rnd < ROUND_B2) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (rnd < ROUND_B3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
  end

  assign t       = {a[26:0], a[31:27]} + f + e + k + wi;
  assign q_pop   = (st == B_LOAD);
  assign advance = ((st == B_LOAD) && q_valid) || (st == B_ROUNDS);
  assign done_ok = !last_blk || !out_valid || m_axis_tready;

  assign sums[0] = chain[0] + a;
  assign sums[1] = chain[1] + b;
  assign sums[2] = chain[2] + c;
  assign sums[3] = chain[3] + d;
  assign sums[4] = chain[4] + e;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      chain_next[i] = last_blk ? H_INIT[i] : sums[i];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_LOAD;
      rnd       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= H_INIT[i];
      end
      a <= H_INIT[0];
      b <= H_INIT[1];
      c <= H_INIT[2];
      d <= H_INIT[3];
      e <= H_INIT[4];
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        a   <= t;
        b   <= a;
        c   <= {b[1:0], b[31:2]};
        d   <= c;
        e   <= d;
        rnd <= rnd + 7'd1;
      end
      case (st)
        B_LOAD: begin
          if (q_valid && (rnd == ROUND_LOADED)) begin
            st <= B_ROUNDS;
          end
        end
        B_ROUNDS: begin
          if (rnd == ROUND_LAST) begin
            st <= B_FINISH;
          end
        end
        B_FINISH: begin
          if (done_ok) begin
            for (int i = 0; i < 5; i++) begin
              chain[i] <= chain_next[i];
            end
            a   <= chain_next[0];
            b   <= chain_next[1];
            c   <= chain_next[2];
            d   <= chain_next[3];
            e   <= chain_next[4];
            rnd <= '0;
            st  <= B_LOAD;
            if (last_blk) begin
              out_valid <= 1'b1;
            end
          end
        end
        default: begin
          st <= B_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 15; i++) begin
        sr[i] <= sr[i+1];
      end
      sr[15] <= wi;
    end
    if ((st == B_LOAD) && q_valid && (rnd == ROUND_LOADED)) begin
      last_blk <= q_data.last_word;
    end
    if ((st == B_FINISH) && done_ok && last_blk) begin
      out_data <= {sums[4], sums[3], sums[2], sums[1], sums[0]};
    end
  end

`ifndef NO_ASSERTIONS
  a_load_range: assert property (@(posedge clk) disable iff (rst)
    (st == B_LOAD) |-> (rnd <= ROUND_LOADED))
    else $error("round count past load phase");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (st == B_ROUNDS) |-> ((rnd >= ROUND_FIRST) && (rnd <= ROUND_LAST)))
    else $error("round count out of range");

  a_digest_init: assert property (@(posedge clk) disable iff (rst)
    ((st == B_FINISH) && done_ok && last_blk) |=> (a == H_INIT[0]) && out_valid)
    else $error("chain not restarted after digest");
`endif

endmodule
